>>> hdl/fvgp_pkg.sv
// Shared constants and types for the FAT16 volume geometry parser.
package fvgp_pkg;

    // Byte positions inside a 512-byte sector
    localparam int unsigned OFS_W = 9;
    localparam logic [OFS_W-1:0] OFS_BOOT_ADDR = 9'h1C6;
    localparam logic [OFS_W-1:0] OFS_SPC       = 9'h00D;
    localparam logic [OFS_W-1:0] OFS_RES       = 9'h00E;
    localparam logic [OFS_W-1:0] OFS_FATS      = 9'h010;
    localparam logic [OFS_W-1:0] OFS_ROOT      = 9'h011;
    localparam logic [OFS_W-1:0] OFS_SPF       = 9'h016;
    localparam logic [OFS_W-1:0] OFS_SIG       = 9'd510;
    localparam logic [OFS_W-1:0] SECTOR_LAST   = 9'd511;

    localparam logic [15:0] BOOT_SIGNATURE = 16'hAA55;
    localparam logic [7:0]  SPC_EXPECTED   = 8'd1;

    // Result kinds
    localparam logic KIND_BOOT_REQ = 1'b0;
    localparam logic KIND_GEOMETRY = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_SIG = 2'd1,
        STATUS_BAD_SPC = 2'd2
    } status_t;

    // Values captured at the last byte of a sector, handed to the geometry stage
    typedef struct packed {
        logic        kind;
        logic        sig_ok;
        logic [15:0] boot_addr;
        logic [7:0]  spc;
        logic [15:0] reserved;
        logic [7:0]  fat_copies;
        logic [15:0] root_entries;
        logic [15:0] fat_length;
    } snap_t;

endpackage

>>> hdl/fvgp_capture.sv
// Byte stream parser: tracks sector offset and phase, captures the sector fields.
module fvgp_capture
    import fvgp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_data_byte,
    input  logic       s_start_req,
    input  logic       s_valid,
    output logic       s_ready,
    output snap_t      snap,
    output logic       snap_valid,
    input  logic       snap_ready
);

    logic             phase_reg;
    logic [OFS_W-1:0] ofs_reg;
    logic [15:0]      boot_addr_reg;
    logic [7:0]       spc_reg;
    logic [15:0]      reserved_reg;
    logic [7:0]       fat_copies_reg;
    logic [15:0]      root_entries_reg;
    logic [15:0]      fat_length_reg;
    logic [7:0]       sig_low_reg;
    snap_t            snap_reg;
    logic             snap_vld_reg;

    logic             accept;
    logic             phase;
    logic [OFS_W-1:0] ofs;
    logic             last;

    // Start request forces the partition phase at offset zero
    assign phase  = s_start_req ? 1'b0 : phase_reg;
    assign ofs    = s_start_req ? '0 : ofs_reg;
    assign last   = (ofs == SECTOR_LAST);
    assign s_ready = !snap_vld_reg || snap_ready;
    assign accept  = s_valid && s_ready;

    assign snap       = snap_reg;
    assign snap_valid = snap_vld_reg;

    // Advance offset and phase, capture fields, load the snapshot at sector end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= 1'b0;
            ofs_reg          <= '0;
            boot_addr_reg    <= '0;
            spc_reg          <= '0;
            reserved_reg     <= '0;
            fat_copies_reg   <= '0;
            root_entries_reg <= '0;
            fat_length_reg   <= '0;
            sig_low_reg      <= '0;
            snap_vld_reg     <= 1'b0;
        end else begin
            if (snap_vld_reg && snap_ready) begin
                snap_vld_reg <= 1'b0;
            end
            if (accept) begin
                if (!phase) begin
                    if (ofs == OFS_BOOT_ADDR) begin
                        boot_addr_reg[7:0] <= s_data_byte;
                    end else if (ofs == OFS_BOOT_ADDR + 9'd1) begin
                        boot_addr_reg[15:8] <= s_data_byte;
                    end
                end else begin
                    if (ofs == OFS_SPC) begin
                        spc_reg <= s_data_byte;
                    end else if (ofs == OFS_RES) begin
                        reserved_reg[7:0] <= s_data_byte;
                    end else if (ofs == OFS_RES + 9'd1) begin
                        reserved_reg[15:8] <= s_data_byte;
                    end else if (ofs == OFS_FATS) begin
                        fat_copies_reg <= s_data_byte;
                    end else if (ofs == OFS_ROOT) begin
                        root_entries_reg[7:0] <= s_data_byte;
                    end else if (ofs == OFS_ROOT + 9'd1) begin
                        root_entries_reg[15:8] <= s_data_byte;
                    end else if (ofs == OFS_SPF) begin
                        fat_length_reg[7:0] <= s_data_byte;
                    end else if (ofs == OFS_SPF + 9'd1) begin
                        fat_length_reg[15:8] <= s_data_byte;
                    end else if (ofs == OFS_SIG) begin
                        sig_low_reg <= s_data_byte;
                    end
                end
                if (last) begin
                    phase_reg             <= !phase;
                    ofs_reg               <= '0;
                    snap_vld_reg          <= 1'b1;
                    snap_reg.kind         <= phase ? KIND_GEOMETRY : KIND_BOOT_REQ;
                    snap_reg.sig_ok       <= ({s_data_byte, sig_low_reg} == BOOT_SIGNATURE);
                    snap_reg.boot_addr    <= boot_addr_reg;
                    snap_reg.spc          <= spc_reg;
                    snap_reg.reserved     <= reserved_reg;
                    snap_reg.fat_copies   <= fat_copies_reg;
                    snap_reg.root_entries <= root_entries_reg;
                    snap_reg.fat_length   <= fat_length_reg;
                end else begin
                    phase_reg <= phase;
                    ofs_reg   <= ofs + 9'd1;
                end
            end
        end
    end

    // A snapshot appears only after a sector's last byte
    a_snap_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(snap_vld_reg) |-> $past(accept && last))
        else $error("snapshot loaded away from sector end");

    // Phase holds between sector ends
    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_start_req && !last |=> phase_reg == $past(phase_reg))
        else $error("phase changed in mid-sector");

endmodule

>>> hdl/fvgp_geometry.sv
// Geometry stage: derives start sectors and status from a snapshot, holds the result.
module fvgp_geometry
    import fvgp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  snap_t       snap,
    input  logic        snap_valid,
    output logic        snap_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic [15:0] m_boot_sector,
    output logic [15:0] m_fat_start,
    output logic [15:0] m_root_dir_start,
    output logic [11:0] m_root_dir_sectors,
    output logic [15:0] m_data_start,
    output logic [15:0] m_root_entries
);

    logic        m_valid_reg;
    logic        kind_reg;
    status_t     status_reg;
    logic [15:0] boot_reg;
    logic [15:0] fat_reg;
    logic [15:0] root_reg;
    logic [11:0] rds_reg;
    logic [15:0] data_reg;
    logic [15:0] entries_reg;

    logic [23:0] fat_prod;
    logic [15:0] fat_next;
    logic [15:0] root_next;
    logic [11:0] rds_next;
    logic [15:0] data_next;
    status_t     status_next;
    logic        geo;

    assign snap_ready = !m_valid_reg || m_ready;
    assign geo        = (snap.kind == KIND_GEOMETRY);

    // Wrapping 16-bit sector arithmetic
    always_comb begin
        fat_prod  = snap.fat_length * snap.fat_copies;
        fat_next  = snap.boot_addr + snap.reserved;
        root_next = fat_next + fat_prod[15:0];
        rds_next  = snap.root_entries[15:4];
        data_next = root_next + {4'd0, rds_next};
        if (!geo) begin
            status_next = STATUS_OK;
        end else if (!snap.sig_ok) begin
            status_next = STATUS_BAD_SIG;
        end else if (snap.spc != SPC_EXPECTED) begin
            status_next = STATUS_BAD_SPC;
        end else begin
            status_next = STATUS_OK;
        end
    end

    // Hold the result until taken, load the next one behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (snap_ready) begin
                m_valid_reg <= snap_valid;
            end
        end
        if (snap_ready && snap_valid) begin
            kind_reg    <= snap.kind;
            status_reg  <= status_next;
            boot_reg    <= snap.boot_addr;
            fat_reg     <= geo ? fat_next : 16'd0;
            root_reg    <= geo ? root_next : 16'd0;
            rds_reg     <= geo ? rds_next : 12'd0;
            data_reg    <= geo ? data_next : 16'd0;
            entries_reg <= geo ? snap.root_entries : 16'd0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = kind_reg;
    assign m_status           = status_reg;
    assign m_boot_sector      = boot_reg;
    assign m_fat_start        = fat_reg;
    assign m_root_dir_start   = root_reg;
    assign m_root_dir_sectors = rds_reg;
    assign m_data_start       = data_reg;
    assign m_root_entries     = entries_reg;

    // A boot address request carries no status and no geometry
    a_req_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == KIND_BOOT_REQ |->
            status_reg == STATUS_OK && fat_reg == 16'd0 && data_reg == 16'd0)
        else $error("boot request carries geometry");

    // Data area follows the root directory
    a_data_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == KIND_GEOMETRY |->
            data_reg == root_reg + {4'd0, rds_reg})
        else $error("data start does not follow root directory");

endmodule

>>> hdl/fat16_volume_geometry_parser_top.sv
// Top level of the FAT16 volume geometry parser.
//
// Input channel (s_): one byte of the sector stream per request, with
// s_start_req marking offset 0 of a new partition sector. The stream is a
// partition sector followed by the boot sector, 512 bytes each.
// Result channel (m_): after the partition sector's last byte, a boot sector
// address request (kind 0); after the boot sector's last byte, a geometry
// result (kind 1) with status, FAT, root directory and data start sectors.
// Throughput: one byte per cycle while s_ready is high. Bytes that end no sector give no result.
// A result reaches m_valid after the last byte of its sector is accepted,
// through the capture register, then the geometry register.
// The geometry register and the capture register each hold one result, so
// a stalled receiver stops input only when both hold a result and a byte
// arrives; with a 512-byte sector between results that is rarely seen.
// Reset (aresetn low, synchronous) clears all captured fields, returns to
// the partition phase at offset 0 and drops any pending result.
module fat16_volume_geometry_parser_top
    import fvgp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_req,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic [15:0] m_boot_sector,
    output logic [15:0] m_fat_start,
    output logic [15:0] m_root_dir_start,
    output logic [11:0] m_root_dir_sectors,
    output logic [15:0] m_data_start,
    output logic [15:0] m_root_entries
);

    snap_t snap;
    logic  snap_valid;
    logic  snap_ready;

    fvgp_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data_byte (s_data_byte),
        .s_start_req (s_start_req),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .snap        (snap),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready)
    );

    fvgp_geometry u_geometry (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .snap               (snap),
        .snap_valid         (snap_valid),
        .snap_ready         (snap_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_status           (m_status),
        .m_boot_sector      (m_boot_sector),
        .m_fat_start        (m_fat_start),
        .m_root_dir_start   (m_root_dir_start),
        .m_root_dir_sectors (m_root_dir_sectors),
        .m_data_start       (m_data_start),
        .m_root_entries     (m_root_entries)
    );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the FAT16 volume geometry parser: sector streams in, geometry checked.
module tb_top
    import fvgp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        kind;
        status_t     status;
        logic [15:0] boot_sector;
        logic [15:0] fat_start;
        logic [15:0] root_dir_start;
        logic [11:0] root_dir_sectors;
        logic [15:0] data_start;
        logic [15:0] root_entries;
    } geometry_t;

    // Mirror of the parse state; predicts one result per finished sector and checks it
    class volume_parse_mirror;
        logic        in_boot;
        logic [8:0]  ofs;
        logic [15:0] boot_addr;
        logic [7:0]  spc;
        logic [15:0] reserved;
        logic [7:0]  fat_copies;
        logic [15:0] root_ent;
        logic [15:0] fat_len;
        logic [7:0]  sig_low;
        geometry_t   pending_geometry[$];
        int          errors;
        int          checked;

        function new();
            in_boot = 1'b0;
            ofs = '0;
            boot_addr = '0;
            spc = '0;
            reserved = '0;
            fat_copies = '0;
            root_ent = '0;
            fat_len = '0;
            sig_low = '0;
            errors = 0;
            checked = 0;
        endfunction

        // Advance the parse by one accepted byte request
        function void note_byte(logic [7:0] b, logic st);
            geometry_t   g;
            logic [15:0] span;
            logic [15:0] sig;
            if (st) begin
                in_boot = 1'b0;
                ofs = '0;
            end
            g.kind = KIND_BOOT_REQ;
            g.status = STATUS_OK;
            g.boot_sector = boot_addr;
            g.fat_start = '0;
            g.root_dir_start = '0;
            g.root_dir_sectors = '0;
            g.data_start = '0;
            g.root_entries = '0;
            if (!in_boot) begin
                if (ofs == OFS_BOOT_ADDR) boot_addr[7:0] = b;
                else if (ofs == OFS_BOOT_ADDR + 9'd1) boot_addr[15:8] = b;
                g.boot_sector = boot_addr;
            end else begin
                case (ofs)
                    OFS_SPC:         spc = b;
                    OFS_RES:         reserved[7:0] = b;
                    OFS_RES + 9'd1:  reserved[15:8] = b;
                    OFS_FATS:        fat_copies = b;
                    OFS_ROOT:        root_ent[7:0] = b;
                    OFS_ROOT + 9'd1: root_ent[15:8] = b;
                    OFS_SPF:         fat_len[7:0] = b;
                    OFS_SPF + 9'd1:  fat_len[15:8] = b;
                    OFS_SIG:         sig_low = b;
                    default: ;
                endcase
                // Bad signature wins over a wrong cluster size
                sig = {b, sig_low};
                if (sig != BOOT_SIGNATURE) g.status = STATUS_BAD_SIG;
                else if (spc != SPC_EXPECTED) g.status = STATUS_BAD_SPC;
                span = fat_len * fat_copies;
                g.kind = KIND_GEOMETRY;
                g.fat_start = boot_addr + reserved;
                g.root_dir_start = g.fat_start + span;
                g.root_dir_sectors = root_ent[15:4];
                g.data_start = g.root_dir_start + {4'd0, g.root_dir_sectors};
                g.root_entries = root_ent;
            end
            if (ofs == SECTOR_LAST) begin
                pending_geometry.push_back(g);
                in_boot = !in_boot;
                ofs = '0;
            end else begin
                ofs = ofs + 9'd1;
            end
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Check one accepted result against the oldest prediction
        function void check_result(geometry_t got);
            geometry_t want;
            if (pending_geometry.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %b boot %h",
                         $time, got.kind, got.boot_sector);
                errors++;
                return;
            end
            want = pending_geometry.pop_front();
            checked++;
            compare("kind", want.kind, got.kind);
            compare("status", want.status, got.status);
            compare("boot_sector", want.boot_sector, got.boot_sector);
            compare("fat_start", want.fat_start, got.fat_start);
            compare("root_dir_start", want.root_dir_start, got.root_dir_start);
            compare("root_dir_sectors", want.root_dir_sectors, got.root_dir_sectors);
            compare("data_start", want.data_start, got.data_start);
            compare("root_entries", want.root_entries, got.root_entries);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic [7:0]  s_data_byte;
    logic        s_start_req;
    logic        s_valid;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [1:0]  m_status;
    logic [15:0] m_boot_sector;
    logic [15:0] m_fat_start;
    logic [15:0] m_root_dir_start;
    logic [11:0] m_root_dir_sectors;
    logic [15:0] m_data_start;
    logic [15:0] m_root_entries;

    volume_parse_mirror tracker = new();
    logic [7:0]  sector_buf [0:511];
    bit          sender_calm;
    bit          rx_held;

    fat16_volume_geometry_parser_top u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_data_byte        (s_data_byte),
        .s_start_req        (s_start_req),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_status           (m_status),
        .m_boot_sector      (m_boot_sector),
        .m_fat_start        (m_fat_start),
        .m_root_dir_start   (m_root_dir_start),
        .m_root_dir_sectors (m_root_dir_sectors),
        .m_data_start       (m_data_start),
        .m_root_entries     (m_root_entries)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watch both channels at each edge
    always @(posedge aclk) begin
        geometry_t got;
        if (aresetn) begin
            if (s_valid && s_ready) tracker.note_byte(s_data_byte, s_start_req);
            if (m_valid && m_ready) begin
                got.kind = m_kind;
                got.status = status_t'(m_status);
                got.boot_sector = m_boot_sector;
                got.fat_start = m_fat_start;
                got.root_dir_start = m_root_dir_start;
                got.root_dir_sectors = m_root_dir_sectors;
                got.data_start = m_data_start;
                got.root_entries = m_root_entries;
                tracker.check_result(got);
            end
        end
    end

    // Send one byte request, idling at random beforehand
    task automatic send_byte(input logic [7:0] b, input logic st);
        while (!sender_calm && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_start_req <= st;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_sector(input logic st, input int len);
        for (int i = 0; i < len; i++) send_byte(sector_buf[i], st && i == 0);
    endtask

    task automatic fill_partition(input logic [15:0] addr);
        foreach (sector_buf[i]) sector_buf[i] = 8'($urandom);
        sector_buf[OFS_BOOT_ADDR] = addr[7:0];
        sector_buf[OFS_BOOT_ADDR + 9'd1] = addr[15:8];
    endtask

    task automatic fill_boot(input logic [7:0] spc, input logic [15:0] res,
                             input logic [7:0] fats, input logic [15:0] root,
                             input logic [15:0] spf, input logic [15:0] sig);
        foreach (sector_buf[i]) sector_buf[i] = 8'($urandom);
        sector_buf[OFS_SPC] = spc;
        sector_buf[OFS_RES] = res[7:0];
        sector_buf[OFS_RES + 9'd1] = res[15:8];
        sector_buf[OFS_FATS] = fats;
        sector_buf[OFS_ROOT] = root[7:0];
        sector_buf[OFS_ROOT + 9'd1] = root[15:8];
        sector_buf[OFS_SPF] = spf[7:0];
        sector_buf[OFS_SPF + 9'd1] = spf[15:8];
        sector_buf[OFS_SIG] = sig[7:0];
        sector_buf[OFS_SIG + 9'd1] = sig[15:8];
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick8();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sig();
        case ($urandom_range(9))
            0: return {BOOT_SIGNATURE[15:8], 8'($urandom)};
            1: return {8'($urandom), BOOT_SIGNATURE[7:0]};
            2: return 16'($urandom);
            default: return BOOT_SIGNATURE;
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off, one stretch without stalls
    initial begin
        m_ready <= 1'b0;
        rx_held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!rx_held && tracker.checked >= 10) begin
                rx_held = 1'b1;
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end
            if (tracker.checked >= 40 && tracker.checked < 55) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(99) >= 27);
        end
    end

    // Stimulus
    initial begin
        int mode;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data_byte <= 8'h00;
        s_start_req <= 1'b0;
        sender_calm = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // First stream after reset without a start flag, all fields zero but cluster size and signature
        fill_partition(16'h0000);
        send_sector(1'b0, 512);
        fill_boot(8'd1, 16'h0000, 8'h00, 16'h0000, 16'h0000, BOOT_SIGNATURE);
        send_sector(1'b0, 512);
        // All fields but cluster size and signature at maximum: every sum wraps
        fill_partition(16'hFFFF);
        send_sector(1'b1, 512);
        fill_boot(8'd1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, BOOT_SIGNATURE);
        send_sector(1'b0, 512);
        // Swapped signature bytes
        fill_partition(16'h8001);
        send_sector(1'b1, 512);
        fill_boot(8'd1, 16'h0020, 8'd2, 16'h0200, 16'h00F2, 16'h55AA);
        send_sector(1'b0, 512);
        // Bad signature and bad cluster size together
        fill_partition(16'h7F3C);
        send_sector(1'b1, 512);
        fill_boot(8'd0, 16'h0001, 8'd1, 16'h0010, 16'h0100, 16'h0000);
        send_sector(1'b0, 512);
        // Cluster size not one, no start flag at the sector boundary
        fill_partition(16'h0101);
        send_sector(1'b0, 512);
        fill_boot(8'd2, 16'h0004, 8'd2, 16'h000F, 16'h00F2, BOOT_SIGNATURE);
        send_sector(1'b0, 512);
        fill_partition(16'hC000);
        send_sector(1'b1, 512);
        fill_boot(8'hFF, 16'h8000, 8'h80, 16'hFFF0, 16'h8001, BOOT_SIGNATURE);
        send_sector(1'b0, 512);
        // Restart mid partition sector after the low address byte
        fill_partition(16'h1234);
        send_sector(1'b1, 9'h1C7);
        fill_partition(16'hABCD);
        send_sector(1'b1, 512);
        // Restart mid boot sector after some fields were captured
        fill_boot(8'd1, 16'h5555, 8'd3, 16'h0033, 16'h0044, BOOT_SIGNATURE);
        send_sector(1'b0, 9'h012);
        fill_partition(16'h2468);
        send_sector(1'b1, 512);
        fill_boot(8'd1, 16'h0008, 8'd2, 16'h0200, 16'h0080, BOOT_SIGNATURE);
        send_sector(1'b0, 512);
        // Start flag on what would be the boot sector's first byte
        fill_partition(16'h0F0F);
        send_sector(1'b1, 512);
        fill_boot(8'd1, 16'h0010, 8'd2, 16'h0100, 16'h0020, BOOT_SIGNATURE);
        send_sector(1'b1, 512);
        fill_boot(8'd1, 16'h0010, 8'd2, 16'h0100, 16'h0020, BOOT_SIGNATURE);
        send_sector(1'b0, 512);

        // Random volumes, mostly well formed, some broken streams
        for (int f = 0; f < 60; f++) begin
            sender_calm = (f >= 20 && f < 24);
            mode = $urandom_range(99);
            if (mode < 80) begin
                fill_partition(pick16());
                send_sector($urandom_range(4) != 0, 512);
                fill_boot(($urandom_range(9) < 7) ? 8'd1 : pick8(), pick16(), pick8(),
                          pick16(), pick16(), pick_sig());
                send_sector(1'b0, 512);
            end else if (mode < 87) begin
                fill_partition(pick16());
                send_sector(1'b1, $urandom_range(1, 511));
            end else if (mode < 94) begin
                fill_partition(pick16());
                send_sector(1'b1, 512);
                fill_boot(pick8(), pick16(), pick8(), pick16(), pick16(), pick_sig());
                send_sector(1'b0, $urandom_range(1, 511));
            end else begin
                repeat ($urandom_range(1, 700)) send_byte(8'($urandom), $urandom_range(63) == 0);
            end
        end
        sender_calm = 1'b0;

        // Drain: wait for every predicted result, then report the verdict
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_geometry.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
